>>> rtl/rtdlin_pkg.sv
package rtdlin_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = 4;
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_VREF   = 2'd2;
    localparam logic [1:0] REG_RUP    = 2'd3;
    localparam logic [31:0] GAIN_RST = 32'd65536;
    localparam logic [23:0] VREF_RST = 24'd3300000;
    localparam logic [31:0] RUP_RST  = 32'd1000000;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;
endpackage

>>> rtl/rtd_divider_temperature_linearizer_top.sv
// An interpolated sample passes three multiplies, two divides and a table scan;
// faulted, clamped or equal-neighbor samples return sooner. One sample in flight;
// the next request is accepted the cycle after the result is registered. A table
// load is written while idle and does not leave the idle state.
// Reset (synchronous, active low) restores register defaults; table not cleared.
module rtd_divider_temperature_linearizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_adc_sample,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_resistance,
    input  logic signed [23:0] i_entry_temperature,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_resistance,
    output logic signed [23:0] o_temperature_fine,
    output logic signed [15:0] o_temperature_short,
    output logic        o_divider_fault,
    output logic        o_short_saturated
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MULV   = 4'd1;
    localparam logic [3:0] S_VCHK   = 4'd2;
    localparam logic [3:0] S_MULR   = 4'd3;
    localparam logic [3:0] S_DIVR   = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_MULT   = 4'd6;
    localparam logic [3:0] S_DIVT   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_SCANRD = 4'd9;

    logic [3:0]  r_state;
    logic [31:0] r_gain, r_rup;
    logic signed [31:0] r_off;
    logic [23:0] r_vref;
    logic [31:0] r_cres [rtdlin_pkg::TABLE_ENTRIES];
    logic signed [23:0] r_ctmp [rtdlin_pkg::TABLE_ENTRIES];

    logic [15:0] r_sample;
    logic signed [33:0] r_v;
    logic [31:0] r_r;
    logic        r_fault;
    logic [rtdlin_pkg::IDX_W-1:0] r_n;
    logic signed [24:0] r_y0;
    logic        r_neg;
    logic [31:0] r_den;
    logic signed [24:0] r_t;
    logic        r_ovalid;

    logic        w_mstart, w_mdone;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    rtdlin_pkg::t_div_req w_dreq;
    logic        w_ddone;
    logic [63:0] w_dq;

    logic signed [34:0] w_v;
    logic [31:0] w_x0, w_x1;
    logic signed [24:0] w_dy;
    logic [24:0] w_mag;
    logic [rtdlin_pkg::IDX_W-1:0] w_n1;

    rtdlin_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_p(w_mp));
    rtdlin_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
        .o_done(w_ddone), .o_q(w_dq));

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_n1 = r_n + 1'b1;
    assign w_x0 = r_cres[r_n];
    assign w_x1 = r_cres[w_n1];
    assign w_dy = 25'(r_ctmp[w_n1]) - 25'(r_ctmp[r_n]);
    assign w_mag = w_dy[24] ? 25'(-w_dy) : 25'(w_dy);
    assign w_v = 35'(signed'({1'b0, w_mp[47:16]})) + 35'(r_off);

    always_comb begin
        w_mstart = 1'b0;
        w_ma = r_gain;
        w_mb = {16'd0, r_sample};
        w_dreq = '0;
        w_dreq.num = w_mp;
        w_dreq.den = 64'(r_den);
        unique case (r_state)
            S_IDLE: begin
                w_mstart = i_valid && !i_kind;
                w_mb = {16'd0, i_adc_sample};
            end
            S_VCHK: begin
                w_mstart = !r_fault;
                w_ma = r_rup;
                w_mb = r_v[31:0];
            end
            S_MULR: begin
                w_dreq.start = w_mdone;
                w_dreq.den = 64'(r_den);
            end
            S_SCAN: begin
                w_mstart = (r_r >= w_x0) && (r_r <= w_x1) && (w_x1 != w_x0);
                w_ma = {7'd0, w_mag};
                w_mb = r_r - w_x0;
            end
            S_MULT: w_dreq.start = w_mdone;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain <= rtdlin_pkg::GAIN_RST;
            r_off <= '0;
            r_vref <= rtdlin_pkg::VREF_RST;
            r_rup <= rtdlin_pkg::RUP_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rtdlin_pkg::REG_GAIN:   r_gain <= i_cfg_data;
                    rtdlin_pkg::REG_OFFSET: r_off <= i_cfg_data;
                    rtdlin_pkg::REG_VREF:   r_vref <= i_cfg_data[23:0];
                    rtdlin_pkg::REG_RUP:    r_rup <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (i_kind) begin
                        r_cres[i_entry_index] <= i_entry_resistance;
                        r_ctmp[i_entry_index] <= i_entry_temperature;
                    end else begin
                        r_sample <= i_adc_sample;
                        r_state <= S_MULV;
                    end
                end
                S_MULV: if (w_mdone) begin
                    r_v <= w_v[33:0];
                    r_fault <= (w_v <= 35'sd0) || (w_v >= 35'(r_vref));
                    r_den <= 32'(35'(r_vref) - w_v);
                    r_state <= S_VCHK;
                end
                S_VCHK: begin
                    r_n <= '0;
                    if (r_fault) begin
                        r_r <= '0;
                        r_state <= S_SCANRD;
                    end else r_state <= S_MULR;
                end
                S_MULR: if (w_mdone) r_state <= S_DIVR;
                S_DIVR: if (w_ddone) begin
                    r_r <= (w_dq[63:32] != 32'd0) ? 32'hFFFF_FFFF : w_dq[31:0];
                    r_state <= S_SCANRD;
                end
                S_SCANRD: begin
                    if (r_r < r_cres[0]) begin
                        r_t <= 25'(r_ctmp[0]);
                        r_state <= S_OUT;
                    end else if (r_r > r_cres[rtdlin_pkg::TABLE_ENTRIES-1]) begin
                        r_t <= 25'(r_ctmp[rtdlin_pkg::TABLE_ENTRIES-1]);
                        r_state <= S_OUT;
                    end else r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_r >= w_x0 && r_r <= w_x1) begin
                        r_y0 <= 25'(r_ctmp[r_n]);
                        r_neg <= w_dy[24];
                        r_den <= w_x1 - w_x0;
                        if (w_x1 == w_x0) begin
                            r_t <= 25'(r_ctmp[r_n]);
                            r_state <= S_OUT;
                        end else r_state <= S_MULT;
                    end else if (w_n1 == 4'(rtdlin_pkg::TABLE_ENTRIES-1)) begin
                        r_t <= '0;
                        r_state <= S_OUT;
                    end else r_n <= w_n1;
                end
                S_MULT: if (w_mdone) r_state <= S_DIVT;
                S_DIVT: if (w_ddone) begin
                    r_t <= r_neg ? r_y0 - 25'(w_dq[24:0]) : r_y0 + 25'(w_dq[24:0]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        o_resistance <= r_r;
                        o_temperature_fine <= r_t[23:0];
                        o_divider_fault <= r_fault;
                        if (r_t > 25'sd32767) begin
                            o_temperature_short <= 16'sh7FFF;
                            o_short_saturated <= 1'b1;
                        end else if (r_t < -25'sd32768) begin
                            o_temperature_short <= 16'sh8000;
                            o_short_saturated <= 1'b1;
                        end else begin
                            o_temperature_short <= r_t[15:0];
                            o_short_saturated <= 1'b0;
                        end
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_ovalid && !i_stall && !(r_state == S_OUT)) r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid) else $error("result dropped");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_fault |-> r_r == 32'd0) else $error("fault r");
`endif
endmodule

>>> rtl/rtdlin_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
module rtdlin_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        n_acc = r_acc;
        n_a = r_a;
        n_b = r_b;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a = {32'd0, i_a};
            n_b = i_b;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = {r_a[62:0], 1'b0};
            n_b = {1'b0, r_b[31:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a <= n_a;
        r_b <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_p = r_acc;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("mul done not a pulse");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("mul done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 6'd32) else $error("mul count overrun");
`endif
endmodule

>>> rtl/rtdlin_div.sv
// Restoring divider: one quotient bit per cycle.
module rtdlin_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtdlin_pkg::t_div_req  i_req,
    output logic                  o_done,
    output logic [63:0]           o_q
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_try;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try = {r_rem[63:0], r_q[63]};
        if (i_req.start) begin
            n_q = i_req.num;
            n_rem = '0;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_done = r_done;
    assign o_q = r_q;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("div done not a pulse");
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_den != 64'd0 |-> r_rem < {1'b0, r_den})
        else $error("div remainder too large");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 7'd64) else $error("div count overrun");
`endif
endmodule
